/* sv/rbv_pkg.sv */
// Shared constants and a helper function for the record bundle validator.
// Holds the hash constants, the magic bytes, the error codes and the register indexes.
// No dependencies.
`default_nettype none

package rbv_pkg;

  localparam int POSITION_BITS_DEF = 24;

  localparam int CFG_DATA_W   = 16;
  localparam int CFG_INDEX_W  = 1;
  localparam int COUNT_W      = 16;
  localparam int OFFSET_W     = 24;
  localparam int HASH_W       = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_RECORDS = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FORMS_MASK  = 1'b1;

  localparam logic [15:0] MAX_RECORDS_RST = 16'd1024;
  localparam logic [7:0]  FORMS_MASK_RST  = 8'hff;

  localparam logic [HASH_W-1:0] HASH_OFFSET = 32'd2166136261;

  localparam logic [7:0] MAGIC_BYTES [4] = '{8'h51, 8'h44, 8'h42, 8'h34};

  localparam logic [7:0] META_HIGH_MASK = 8'hf0;
  localparam logic [1:0] META_DEPTH_BAD = 2'b11;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_TRUNC    = 3'd1;
  localparam logic [2:0] ERR_MAGIC    = 3'd2;
  localparam logic [2:0] ERR_COUNT    = 3'd3;
  localparam logic [2:0] ERR_META     = 3'd4;
  localparam logic [2:0] ERR_FORMS    = 3'd5;
  localparam logic [2:0] ERR_TRAILING = 3'd6;
  localparam logic [2:0] ERR_TOO_LONG = 3'd7;

  // One FNV-1a step. The prime is 2^24 + 403, so the product is a sum of shifts.
  function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                 input logic [7:0] b);
    logic [HASH_W-1:0] x;
    x = h ^ {24'h000000, b};
    return (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

`default_nettype wire

/* sv/record_bundle_validator.sv */
// Top level of the record bundle validator: byte parser, FNV-1a hash and result register.
// Depends on rbv_pkg for constants, error codes and the hash step.
//
// The block takes one bundle byte per cycle, back to back, with no gaps needed between
// bundles. Each accepted byte goes into an input register; from there the parser state
// and the 32-bit hash are updated from it, and on the byte marked last the result is
// loaded into the output register, which raises out_valid. The rate of one byte per
// cycle is set by the update loop of the parser state and the shift-add hash step. The
// input stalls only when a last byte waits in the input register while an earlier
// result is still held.
`default_nettype none

module record_bundle_validator #(
  parameter int POSITION_BITS = rbv_pkg::POSITION_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_wr_en,
  input  wire logic [rbv_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [rbv_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [7:0]                       in_byte_value,
  input  wire logic                             in_last_byte,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  out_accepted,
  output logic [2:0]                            out_error_code,
  output logic [rbv_pkg::COUNT_W-1:0]           out_record_count,
  output logic [7:0]                            out_version_length,
  output logic [7:0]                            out_language_length,
  output logic [rbv_pkg::OFFSET_W-1:0]          out_first_record_offset,
  output logic [rbv_pkg::HASH_W-1:0]            out_fingerprint
);

  localparam logic [2:0] SEC_MAGIC  = 3'd0;
  localparam logic [2:0] SEC_VLEN   = 3'd1;
  localparam logic [2:0] SEC_VSTR   = 3'd2;
  localparam logic [2:0] SEC_LLEN   = 3'd3;
  localparam logic [2:0] SEC_LSTR   = 3'd4;
  localparam logic [2:0] SEC_COUNT  = 3'd5;
  localparam logic [2:0] SEC_HEADER = 3'd6;
  localparam logic [2:0] SEC_TEXT   = 3'd7;

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

  // Configuration registers.
  logic [15:0] max_rec_r;
  logic [7:0]  forms_mask_r;

  // Input register.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       s1_fire;

  // Parser state.
  logic [2:0]                        sec_r, sec_nxt;
  logic [POSITION_BITS-1:0]          pos_r, pos_nxt;
  logic [POSITION_BITS-1:0]          pos_inc;
  logic [15:0]                       frem_r, frem_nxt;
  logic [15:0]                       rleft_r, rleft_nxt;
  logic [rbv_pkg::COUNT_W-1:0]       count_r, count_nxt;
  logic [2:0]                        hfault_r, hfault_nxt;
  logic [2:0]                        ffault_r, ffault_nxt;
  logic [rbv_pkg::HASH_W-1:0]        hash_r, hash_nxt;
  logic [7:0]                        vlen_r, vlen_nxt;
  logic [7:0]                        llen_r, llen_nxt;
  logic [rbv_pkg::OFFSET_W-1:0]      foff_r, foff_nxt;

  logic [2:0]  err;
  logic [15:0] count_full;
  logic        bad_magic;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_rec_r    <= rbv_pkg::MAX_RECORDS_RST;
      forms_mask_r <= rbv_pkg::FORMS_MASK_RST;
    end else if (cfg_wr_en) begin
      if (cfg_index == rbv_pkg::CFG_MAX_RECORDS) begin
        max_rec_r <= cfg_data;
      end
      if (cfg_index == rbv_pkg::CFG_FORMS_MASK) begin
        forms_mask_r <= cfg_data[7:0];
      end
    end
  end

  assign s1_fire  = s1_valid_r && !(s1_last_r && out_valid && out_stall);
  assign in_stall = s1_valid_r && !s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_byte_value;
      s1_last_r <= in_last_byte;
    end
  end

  assign pos_inc    = pos_r + POS_ONE;
  assign count_full = {s1_byte_r, count_r[7:0]};
  assign bad_magic  = s1_byte_r != rbv_pkg::MAGIC_BYTES[pos_r[1:0]];

  always_comb begin
    sec_nxt    = sec_r;
    pos_nxt    = pos_r;
    frem_nxt   = frem_r;
    rleft_nxt  = rleft_r;
    count_nxt  = count_r;
    hfault_nxt = hfault_r;
    ffault_nxt = ffault_r;
    hash_nxt   = hash_r;
    vlen_nxt   = vlen_r;
    llen_nxt   = llen_r;
    foff_nxt   = foff_r;
    err        = rbv_pkg::ERR_NONE;
    if (s1_fire) begin
      hash_nxt = rbv_pkg::fnv_step(hash_r, s1_byte_r);
      if (pos_r == POS_MAX) begin
        if (ffault_r == rbv_pkg::ERR_NONE) begin
          ffault_nxt = rbv_pkg::ERR_TOO_LONG;
        end
      end else begin
        pos_nxt = pos_inc;
        if (ffault_r == rbv_pkg::ERR_NONE) begin
          unique case (sec_r)
            SEC_MAGIC: begin
              if (bad_magic) begin
                hfault_nxt = rbv_pkg::ERR_MAGIC;
              end
              if (pos_r[1:0] == 2'd3) begin
                ffault_nxt = bad_magic ? rbv_pkg::ERR_MAGIC : hfault_r;
                hfault_nxt = rbv_pkg::ERR_NONE;
                sec_nxt    = SEC_VLEN;
              end
            end
            SEC_VLEN: begin
              vlen_nxt = s1_byte_r;
              frem_nxt = {8'h00, s1_byte_r};
              sec_nxt  = (s1_byte_r != 8'h00) ? SEC_VSTR : SEC_LLEN;
            end
            SEC_VSTR: begin
              frem_nxt = frem_r - 16'd1;
              if (frem_r == 16'd1) begin
                sec_nxt = SEC_LLEN;
              end
            end
            SEC_LLEN: begin
              llen_nxt = s1_byte_r;
              frem_nxt = {8'h00, s1_byte_r};
              sec_nxt  = (s1_byte_r != 8'h00) ? SEC_LSTR : SEC_COUNT;
            end
            SEC_LSTR: begin
              frem_nxt = frem_r - 16'd1;
              if (frem_r == 16'd1) begin
                sec_nxt = SEC_COUNT;
              end
            end
            SEC_COUNT: begin
              if (frem_r == 16'd0) begin
                count_nxt = {8'h00, s1_byte_r};
                frem_nxt  = 16'd1;
              end else begin
                count_nxt = count_full;
                frem_nxt  = 16'd0;
                rleft_nxt = count_full;
                foff_nxt  = rbv_pkg::OFFSET_W'(pos_inc);
                if (count_full > max_rec_r) begin
                  ffault_nxt = rbv_pkg::ERR_COUNT;
                end else begin
                  sec_nxt = SEC_TEXT;
                end
              end
            end
            SEC_HEADER: begin
              if (frem_r[1:0] == 2'd1) begin
                if (hfault_r == rbv_pkg::ERR_NONE && (s1_byte_r & ~forms_mask_r) != 8'h00) begin
                  hfault_nxt = rbv_pkg::ERR_FORMS;
                end
                frem_nxt = 16'd2;
              end else if (frem_r[1:0] == 2'd2) begin
                frem_nxt = {s1_byte_r, 8'h03};
              end else begin
                rleft_nxt = rleft_r - 16'd1;
                if (hfault_r != rbv_pkg::ERR_NONE) begin
                  ffault_nxt = hfault_r;
                  hfault_nxt = rbv_pkg::ERR_NONE;
                end else begin
                  sec_nxt  = SEC_TEXT;
                  frem_nxt = {s1_byte_r, frem_r[15:8]};
                end
              end
            end
            SEC_TEXT: begin
              if (frem_r != 16'd0) begin
                frem_nxt = frem_r - 16'd1;
              end else if (rleft_r != 16'd0) begin
                hfault_nxt = ((s1_byte_r & rbv_pkg::META_HIGH_MASK) != 8'h00 ||
                              s1_byte_r[1:0] == rbv_pkg::META_DEPTH_BAD) ?
                             rbv_pkg::ERR_META : rbv_pkg::ERR_NONE;
                frem_nxt   = 16'd1;
                sec_nxt    = SEC_HEADER;
              end else begin
                ffault_nxt = rbv_pkg::ERR_TRAILING;
              end
            end
            default: begin
              sec_nxt = sec_r;
            end
          endcase
        end
      end
      if (ffault_nxt != rbv_pkg::ERR_NONE) begin
        err = ffault_nxt;
      end else if (!(sec_nxt == SEC_TEXT && frem_nxt == 16'd0 && rleft_nxt == 16'd0)) begin
        err = rbv_pkg::ERR_TRUNC;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (s1_fire && s1_last_r)) begin
      sec_r    <= SEC_MAGIC;
      pos_r    <= '0;
      frem_r   <= 16'd0;
      rleft_r  <= 16'd0;
      count_r  <= '0;
      hfault_r <= rbv_pkg::ERR_NONE;
      ffault_r <= rbv_pkg::ERR_NONE;
      hash_r   <= rbv_pkg::HASH_OFFSET;
      vlen_r   <= 8'h00;
      llen_r   <= 8'h00;
      foff_r   <= '0;
    end else begin
      sec_r    <= sec_nxt;
      pos_r    <= pos_nxt;
      frem_r   <= frem_nxt;
      rleft_r  <= rleft_nxt;
      count_r  <= count_nxt;
      hfault_r <= hfault_nxt;
      ffault_r <= ffault_nxt;
      hash_r   <= hash_nxt;
      vlen_r   <= vlen_nxt;
      llen_r   <= llen_nxt;
      foff_r   <= foff_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      out_accepted            <= err == rbv_pkg::ERR_NONE;
      out_error_code          <= err;
      out_record_count        <= count_nxt;
      out_version_length      <= vlen_nxt;
      out_language_length     <= llen_nxt;
      out_first_record_offset <= foff_nxt;
      out_fingerprint         <= (err == rbv_pkg::ERR_NONE) ? hash_nxt : '0;
    end
  end

  // The input side stalls only behind a held result with a last item waiting.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s1_last_r && out_valid && out_stall))
    else $error("input stalled without a pending result");

  a_accept_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_accepted == (out_error_code == rbv_pkg::ERR_NONE)))
    else $error("accepted flag disagrees with error code");

  a_reject_print: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_accepted) |-> (out_fingerprint == '0))
    else $error("rejected bundle carries a fingerprint");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r) |=> (pos_r == '0 && hash_r == rbv_pkg::HASH_OFFSET &&
                               sec_r == SEC_MAGIC && ffault_r == rbv_pkg::ERR_NONE))
    else $error("parser state not cleared after a bundle");

endmodule

`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for record_bundle_validator: streams byte bundles, predicts
// every verdict with an in-bench parser and compares each result field by field.
// Depends on rbv_pkg and the record_bundle_validator RTL only.

module tb;

  localparam int POS_BITS = 12;
  localparam logic [POS_BITS-1:0] POS_MAX = '1;
  localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);
  localparam logic [31:0] FNV_PRIME = 32'd16777619;
  localparam int LIMIT = 1000000;
  localparam int HOLD_CYCLES = 200;
  localparam int RANDOM_OCTETS = 150;
  localparam int RANDOM_RESULTS = 8;

  typedef enum logic [2:0] {
    SEG_MAGIC, SEG_VLEN, SEG_VTEXT, SEG_LLEN, SEG_LTEXT, SEG_COUNT, SEG_HEAD, SEG_BODY
  } seg_t;

  typedef struct packed {
    logic        accepted;
    logic [2:0]  error_code;
    logic [15:0] record_count;
    logic [7:0]  version_length;
    logic [7:0]  language_length;
    logic [23:0] first_record_offset;
    logic [31:0] fingerprint;
  } bundle_verdict_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [rbv_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [rbv_pkg::CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [7:0] in_byte_value;
  logic in_last_byte;
  logic out_valid;
  logic out_stall;
  logic out_accepted;
  logic [2:0] out_error_code;
  logic [rbv_pkg::COUNT_W-1:0] out_record_count;
  logic [7:0] out_version_length;
  logic [7:0] out_language_length;
  logic [rbv_pkg::OFFSET_W-1:0] out_first_record_offset;
  logic [rbv_pkg::HASH_W-1:0] out_fingerprint;

  // Parser state mirrored by the predictor.
  logic [15:0] max_recs;
  logic [7:0] forms_mask;
  seg_t seg;
  logic [POS_BITS-1:0] pos;
  logic [15:0] field_left;
  logic [15:0] recs_left;
  logic [15:0] count_rd;
  logic [2:0] hdr_fault;
  logic [2:0] fault;
  logic [31:0] hash;
  logic [7:0] vlen;
  logic [7:0] llen;
  logic [23:0] first_off;

  bundle_verdict_t pending[$];
  logic [7:0] bundle_q[$];
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int octets_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int cycles = 0;

  record_bundle_validator #(.POSITION_BITS(POS_BITS)) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_byte_value(in_byte_value),
    .in_last_byte(in_last_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_accepted(out_accepted),
    .out_error_code(out_error_code),
    .out_record_count(out_record_count),
    .out_version_length(out_version_length),
    .out_language_length(out_language_length),
    .out_first_record_offset(out_first_record_offset),
    .out_fingerprint(out_fingerprint)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic void clear_parse();
    seg = SEG_MAGIC;
    pos = '0;
    field_left = 16'd0;
    recs_left = 16'd0;
    count_rd = 16'd0;
    hdr_fault = rbv_pkg::ERR_NONE;
    fault = rbv_pkg::ERR_NONE;
    hash = rbv_pkg::HASH_OFFSET;
    vlen = 8'd0;
    llen = 8'd0;
    first_off = 24'd0;
  endfunction

  function automatic void parse_octet(input logic [7:0] b);
    logic [15:0] body_len;
    logic [23:0] pos_wide;
    pos_wide = 24'(pos);
    case (seg)
      SEG_MAGIC: begin
        if (b != rbv_pkg::MAGIC_BYTES[pos[1:0]]) hdr_fault = rbv_pkg::ERR_MAGIC;
        if (pos[1:0] == 2'd3) begin
          fault = hdr_fault;
          hdr_fault = rbv_pkg::ERR_NONE;
          seg = SEG_VLEN;
        end
      end
      SEG_VLEN: begin
        vlen = b;
        field_left = {8'd0, b};
        seg = (b != 8'd0) ? SEG_VTEXT : SEG_LLEN;
      end
      SEG_VTEXT: begin
        field_left = field_left - 16'd1;
        if (field_left == 16'd0) seg = SEG_LLEN;
      end
      SEG_LLEN: begin
        llen = b;
        field_left = {8'd0, b};
        seg = (b != 8'd0) ? SEG_LTEXT : SEG_COUNT;
      end
      SEG_LTEXT: begin
        field_left = field_left - 16'd1;
        if (field_left == 16'd0) seg = SEG_COUNT;
      end
      SEG_COUNT: begin
        if (field_left == 16'd0) begin
          count_rd = {8'd0, b};
          field_left = 16'd1;
        end else begin
          count_rd[15:8] = b;
          field_left = 16'd0;
          recs_left = count_rd;
          first_off = pos_wide + 24'd1;
          if (count_rd > max_recs) fault = rbv_pkg::ERR_COUNT;
          else seg = SEG_BODY;
        end
      end
      SEG_HEAD: begin
        case (field_left[1:0])
          2'd1: begin
            if (hdr_fault == rbv_pkg::ERR_NONE && (b & ~forms_mask) != 8'd0)
              hdr_fault = rbv_pkg::ERR_FORMS;
            field_left = 16'd2;
          end
          2'd2: field_left = {b, 8'd3};
          default: begin
            body_len = {b, field_left[15:8]};
            recs_left = recs_left - 16'd1;
            if (hdr_fault != rbv_pkg::ERR_NONE) begin
              fault = hdr_fault;
              hdr_fault = rbv_pkg::ERR_NONE;
            end else begin
              seg = SEG_BODY;
              field_left = body_len;
            end
          end
        endcase
      end
      default: begin
        if (field_left != 16'd0) begin
          field_left = field_left - 16'd1;
        end else if (recs_left != 16'd0) begin
          hdr_fault = ((b & rbv_pkg::META_HIGH_MASK) != 8'd0 ||
                       b[1:0] == rbv_pkg::META_DEPTH_BAD) ?
                      rbv_pkg::ERR_META : rbv_pkg::ERR_NONE;
          field_left = 16'd1;
          seg = SEG_HEAD;
        end else begin
          fault = rbv_pkg::ERR_TRAILING;
        end
      end
    endcase
  endfunction

  function automatic bit fold_octet(input logic [7:0] b, input logic last,
                                    output bundle_verdict_t v);
    logic [2:0] err;
    hash = (hash ^ {24'd0, b}) * FNV_PRIME;
    if (pos == POS_MAX) begin
      if (fault == rbv_pkg::ERR_NONE) fault = rbv_pkg::ERR_TOO_LONG;
    end else begin
      if (fault == rbv_pkg::ERR_NONE) parse_octet(b);
      pos = pos + POS_ONE;
    end
    v = '0;
    if (!last) return 1'b0;
    err = fault;
    if (err == rbv_pkg::ERR_NONE &&
        !(seg == SEG_BODY && field_left == 16'd0 && recs_left == 16'd0))
      err = rbv_pkg::ERR_TRUNC;
    v.accepted = (err == rbv_pkg::ERR_NONE);
    v.error_code = err;
    v.record_count = count_rd;
    v.version_length = vlen;
    v.language_length = llen;
    v.first_record_offset = first_off;
    v.fingerprint = (err == rbv_pkg::ERR_NONE) ? hash : 32'd0;
    clear_parse();
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] good_meta();
    logic [1:0] spare;
    logic [1:0] depth;
    spare = 2'($urandom_range(0, 3));
    depth = 2'($urandom_range(0, 2));
    return {4'h0, spare, depth};
  endfunction

  function automatic void begin_bundle();
    bundle_q.delete();
    for (int i = 0; i < 4; i++) bundle_q.push_back(rbv_pkg::MAGIC_BYTES[i]);
  endfunction

  function automatic void add_prefix(input int vl, input int ll);
    bundle_q.push_back(vl[7:0]);
    repeat (vl) bundle_q.push_back(8'($urandom_range(0, 255)));
    bundle_q.push_back(ll[7:0]);
    repeat (ll) bundle_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void add_count(input int n);
    bundle_q.push_back(n[7:0]);
    bundle_q.push_back(n[15:8]);
  endfunction

  function automatic void add_record(input logic [7:0] meta, input logic [7:0] forms,
                                     input int tlen);
    bundle_q.push_back(meta);
    bundle_q.push_back(forms);
    bundle_q.push_back(tlen[7:0]);
    bundle_q.push_back(tlen[15:8]);
    repeat (tlen) bundle_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    bundle_verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result, error_code", 32'(out_error_code), 32'd0);
      end else begin
        want = pending.pop_front();
        if (out_accepted !== want.accepted)
          report_mismatch("accepted", 32'(out_accepted), 32'(want.accepted));
        if (out_error_code !== want.error_code)
          report_mismatch("error_code", 32'(out_error_code), 32'(want.error_code));
        if (out_record_count !== want.record_count)
          report_mismatch("record_count", 32'(out_record_count), 32'(want.record_count));
        if (out_version_length !== want.version_length)
          report_mismatch("version_length", 32'(out_version_length),
                          32'(want.version_length));
        if (out_language_length !== want.language_length)
          report_mismatch("language_length", 32'(out_language_length),
                          32'(want.language_length));
        if (out_first_record_offset !== want.first_record_offset)
          report_mismatch("first_record_offset", 32'(out_first_record_offset),
                          32'(want.first_record_offset));
        if (out_fingerprint !== want.fingerprint)
          report_mismatch("fingerprint", out_fingerprint, want.fingerprint);
      end
    end
  end

  // The result side stalls at random unless calm is set; on request it holds off for a long stretch.
  initial begin : result_sink
    int n;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        n = calm ? 0 : pick_gap();
        if (n == 0) begin
          out_stall <= 1'b0;
        end else begin
          out_stall <= 1'b1;
          repeat (n - 1) @(posedge clk);
        end
      end
    end
  end

  task automatic send_octet(input logic [7:0] b, input logic last);
    int gap;
    bundle_verdict_t v;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte_value <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (fold_octet(b, last, v)) pending.push_back(v);
    octets_sent++;
  endtask

  task automatic ship(input int keep);
    int n;
    n = (keep > 0 && keep < bundle_q.size()) ? keep : bundle_q.size();
    for (int i = 0; i < n; i++) send_octet(bundle_q[i], i == n - 1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rbv_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [15:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    if (idx == rbv_pkg::CFG_MAX_RECORDS) max_recs = data;
    else forms_mask = data[7:0];
  endtask

  task automatic set_limits(input logic [15:0] max_count, input logic [7:0] mask);
    logic [7:0] junk;
    junk = 8'($urandom_range(0, 255));
    write_reg(rbv_pkg::CFG_MAX_RECORDS, max_count);
    write_reg(rbv_pkg::CFG_FORMS_MASK, {junk, mask});
  endtask

  task automatic test_good_bundles();
    begin_bundle();
    add_prefix(0, 0);
    add_count(0);
    ship(0);
    begin_bundle();
    add_prefix(3, 2);
    add_count(2);
    add_record(8'h00, 8'hff, 0);
    add_record(8'h0e, 8'h00, 5);
    ship(0);
    begin_bundle();
    add_prefix(255, 2);
    add_count(1);
    add_record(8'h06, 8'h5a, 1);
    ship(0);
  endtask

  task automatic test_fault_cases();
    bundle_q.delete();
    bundle_q.push_back(rbv_pkg::MAGIC_BYTES[0]);
    ship(0);
    for (int k = 0; k < 4; k++) begin
      begin_bundle();
      add_prefix(1, 0);
      add_count(0);
      bundle_q[k] = bundle_q[k] ^ 8'h80;
      ship(0);
    end
    // A wrong magic byte inside an unfinished magic reads as truncation.
    begin_bundle();
    bundle_q[1] = 8'h00;
    ship(2);
    begin_bundle();
    add_prefix(0, 0);
    add_count(1);
    add_record(8'h10, 8'h00, 2);
    ship(0);
    begin_bundle();
    add_prefix(0, 0);
    add_count(1);
    add_record(8'h03, 8'h00, 0);
    ship(0);
    begin_bundle();
    add_prefix(0, 0);
    add_count(1);
    add_record(8'hf3, 8'h00, 0);
    ship(bundle_q.size() - 2);
    begin_bundle();
    add_prefix(0, 0);
    add_count(1025);
    add_record(8'h00, 8'h00, 1);
    ship(0);
    begin_bundle();
    add_prefix(0, 0);
    add_count(1024);
    ship(0);
    begin_bundle();
    add_prefix(2, 0);
    add_count(1);
    add_record(8'h00, 8'h00, 1);
    bundle_q.push_back(8'h00);
    ship(0);
    begin_bundle();
    add_prefix(0, 3);
    add_count(1);
    add_record(8'h01, 8'hff, 6);
    ship(bundle_q.size() - 2);
    begin_bundle();
    add_prefix(5, 0);
    ship(7);
    // The magic fault must survive the trailing bytes that follow.
    begin_bundle();
    bundle_q[0] = 8'h00;
    add_prefix(0, 0);
    add_count(0);
    repeat (3) bundle_q.push_back(8'hff);
    ship(0);
  endtask

  task automatic test_register_extremes();
    drain();
    set_limits(16'd0, 8'h00);
    begin_bundle();
    add_prefix(0, 0);
    add_count(1);
    add_record(8'h00, 8'h00, 0);
    ship(0);
    begin_bundle();
    add_prefix(0, 0);
    add_count(0);
    ship(0);
    drain();
    set_limits(16'hffff, 8'h00);
    begin_bundle();
    add_prefix(1, 1);
    add_count(65535);
    add_record(8'h00, 8'h00, 1);
    add_record(8'h04, 8'h00, 0);
    ship(0);
    begin_bundle();
    add_prefix(0, 0);
    add_count(1);
    add_record(8'h00, 8'h80, 0);
    ship(0);
    begin_bundle();
    add_prefix(0, 0);
    add_count(2);
    add_record(8'h00, 8'h00, 1);
    add_record(8'hf0, 8'h01, 0);
    ship(0);
    begin_bundle();
    add_prefix(0, 0);
    add_count(1);
    add_record(8'h01, 8'h01, 0);
    ship(bundle_q.size() - 2);
    drain();
    set_limits(16'd1024, 8'h0f);
    begin_bundle();
    add_prefix(0, 0);
    add_count(2);
    add_record(8'h02, 8'h0f, 1);
    add_record(8'h02, 8'h10, 0);
    ship(0);
    begin_bundle();
    add_prefix(0, 0);
    add_count(1);
    add_record(8'h02, 8'h0f, 1);
    ship(0);
    drain();
    set_limits(rbv_pkg::MAX_RECORDS_RST, rbv_pkg::FORMS_MASK_RST);
  endtask

  task automatic test_backpressure();
    drain();
    calm = 1'b1;
    hold_req = 1'b1;
    repeat (6) begin
      begin_bundle();
      add_prefix(0, 1);
      add_count(0);
      ship(0);
    end
    drain();
    calm = 1'b0;
  endtask

  task automatic test_random_bundles();
    int n_bundles;
    int kind;
    int vl;
    int ll;
    int nrec;
    int hdr_at;
    int cut;
    int k;
    int start_octets;
    int start_results;
    logic [7:0] rnd;
    logic [15:0] lim;
    logic [7:0] mask;
    n_bundles = 0;
    start_octets = octets_sent;
    start_results = results_seen;
    while (octets_sent - start_octets < RANDOM_OCTETS ||
           results_seen - start_results < RANDOM_RESULTS) begin
      if (n_bundles % 8 == 0) begin
        drain();
        calm = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 3))
          0: lim = 16'($urandom_range(0, 3));
          1: lim = 16'd1024;
          2: lim = 16'hffff;
          default: lim = 16'($urandom_range(0, 65535));
        endcase
        case ($urandom_range(0, 3))
          0: mask = 8'h00;
          1: mask = 8'($urandom_range(0, 255));
          default: mask = 8'hff;
        endcase
        set_limits(lim, mask);
      end
      n_bundles++;
      kind = $urandom_range(0, 99);
      cut = 0;
      if (kind < 90) begin
        vl = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 40) : $urandom_range(0, 3);
        ll = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 40) : $urandom_range(0, 3);
        nrec = $urandom_range(0, 3);
        begin_bundle();
        add_prefix(vl, ll);
        add_count(nrec);
        hdr_at = bundle_q.size();
        repeat (nrec) begin
          rnd = 8'($urandom_range(0, 255));
          add_record(good_meta(), rnd & forms_mask,
                     ($urandom_range(0, 29) == 0) ? $urandom_range(256, 300)
                                                  : $urandom_range(0, 4));
        end
        if (kind >= 65) begin
          rnd = 8'($urandom_range(1, 255));
          case ($urandom_range(0, 5))
            0: cut = $urandom_range(1, bundle_q.size() - 1);
            1: begin
              k = $urandom_range(0, bundle_q.size() - 1);
              bundle_q[k] = bundle_q[k] ^ rnd;
            end
            2: repeat ($urandom_range(1, 3)) bundle_q.push_back(8'($urandom_range(0, 255)));
            3: begin
              k = $urandom_range(0, 3);
              bundle_q[k] = bundle_q[k] ^ rnd;
            end
            4: bundle_q[hdr_at - 2] = bundle_q[hdr_at - 2] + 8'd1;
            default: if (nrec > 0) bundle_q[hdr_at] = rnd;
          endcase
        end
      end else begin
        bundle_q.delete();
        if ($urandom_range(0, 1) == 1)
          for (int i = 0; i < 4; i++) bundle_q.push_back(rbv_pkg::MAGIC_BYTES[i]);
        repeat ($urandom_range(1, 10)) bundle_q.push_back(8'($urandom_range(0, 255)));
      end
      ship(cut);
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_byte_value <= 8'd0;
    in_last_byte <= 1'b0;
    max_recs = rbv_pkg::MAX_RECORDS_RST;
    forms_mask = rbv_pkg::FORMS_MASK_RST;
    clear_parse();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_good_bundles();
    test_fault_cases();
    test_register_extremes();
    test_backpressure();
    test_random_bundles();
    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
